// ===== hw/rtl/vector3_normalize_macros.svh =====
// assertion macros for the vector3_normalize block
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define V3N_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define V3N_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define V3N_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define V3N_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/v3n_pkg.sv =====
// shared constants, types and helpers for the vector normalizer
`timescale 1ns / 1ps
package v3n_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int LANES           = 3;
    localparam int SUM_W           = 2 * COMPONENT_WIDTH;
    localparam int ROOT_W          = COMPONENT_WIDTH;
    localparam int UNIT_FRAC       = 14;
    localparam int QUOT_W          = UNIT_FRAC + 1;
    localparam int DIV_W           = ROOT_W + QUOT_W;
    localparam int OUT_W           = 16;
    localparam logic [OUT_W-1:0] MAG_MAX = '1;

    typedef logic [COMPONENT_WIDTH-1:0] comp_t;
    typedef logic [SUM_W-1:0]           sum_t;
    typedef logic [ROOT_W-1:0]          root_t;
    typedef logic [QUOT_W-1:0]          quot_t;
    typedef logic [DIV_W-1:0]           div_t;

    // absolute values and signs of the three components
    typedef struct packed {
        logic [LANES-1:0][COMPONENT_WIDTH-1:0] abs_val;
        logic [LANES-1:0]                      neg;
    } side_t;

    // magnitude clamp to the 16-bit output field
    function automatic logic [OUT_W-1:0] sat_mag(input root_t m);
        logic [OUT_W-1:0] r;
        if (64'(m) > 64'(MAG_MAX))
            r = MAG_MAX;
        else
            r = OUT_W'(m);
        return r;
    endfunction

endpackage

// ===== hw/rtl/v3n_sqsum.sv =====
// absolute value, squaring and sum of squares, three stages
`timescale 1ns / 1ps
module v3n_sqsum (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [v3n_pkg::COMPONENT_WIDTH-1:0] vec_x,
    input  logic signed [v3n_pkg::COMPONENT_WIDTH-1:0] vec_y,
    input  logic signed [v3n_pkg::COMPONENT_WIDTH-1:0] vec_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output v3n_pkg::sum_t                         sum,
    output v3n_pkg::side_t                        side
);
    import v3n_pkg::*;

    localparam int NSTG = 3;

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   rdy;

    side_t side0_reg, side1_reg, side2_reg;
    side_t side0_next;
    sum_t  sq_reg [LANES];
    sum_t  sum_reg;
    comp_t comp_in [LANES];

    assign rdy[NSTG] = out_ready;
    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_rdy
            assign rdy[k] = !v_reg[k] || rdy[k+1];
        end
    endgenerate

    assign comp_in[0] = comp_t'(vec_x);
    assign comp_in[1] = comp_t'(vec_y);
    assign comp_in[2] = comp_t'(vec_z);

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            side0_next.neg[l]     = comp_in[l][COMPONENT_WIDTH-1];
            side0_next.abs_val[l] = comp_in[l][COMPONENT_WIDTH-1]
                                  ? (~comp_in[l] + comp_t'(1)) : comp_in[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int s = 1; s < NSTG; s++)
            begin
                if (rdy[s])
                    v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            side0_reg <= side0_next;
        if (rdy[1])
        begin
            side1_reg <= side0_reg;
            for (int l = 0; l < LANES; l++)
                sq_reg[l] <= sum_t'(side0_reg.abs_val[l]) * sum_t'(side0_reg.abs_val[l]);
        end
        if (rdy[2])
        begin
            side2_reg <= side1_reg;
            sum_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NSTG-1];
    assign sum       = sum_reg;
    assign side      = side2_reg;

endmodule

// ===== hw/rtl/v3n_sqrt.sv =====
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module v3n_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  v3n_pkg::sum_t  sum,
    input  v3n_pkg::side_t side_in,
    output logic           out_valid,
    input  logic           out_ready,
    output v3n_pkg::root_t mag,
    output v3n_pkg::side_t side_out
);
    import v3n_pkg::*;

    localparam int NSTG = ROOT_W;

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   rdy;

    sum_t  rem_reg  [NSTG];
    root_t root_reg [NSTG];
    side_t side_reg [NSTG];

    assign rdy[NSTG] = out_ready;

    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_stage
            localparam int BIT = NSTG - 1 - k;
            sum_t  rem_prev;
            root_t root_prev;
            side_t side_prev;
            sum_t  trial;
            logic  take;

            assign rdy[k] = !v_reg[k] || rdy[k+1];

            if (k == 0) begin : g_first
                assign rem_prev  = sum;
                assign root_prev = '0;
                assign side_prev = side_in;
            end else begin : g_next
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            // (root + 2^i)^2 - root^2
            assign trial = (sum_t'(root_prev) << (BIT + 1)) | (sum_t'(1) << (2 * BIT));
            assign take  = rem_prev >= trial;

            always_ff @(posedge clk)
            begin
                if (rdy[k])
                begin
                    rem_reg[k]  <= take ? (rem_prev - trial) : rem_prev;
                    root_reg[k] <= take ? (root_prev | (root_t'(1) << BIT)) : root_prev;
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int s = 1; s < NSTG; s++)
            begin
                if (rdy[s])
                    v_reg[s] <= v_reg[s-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NSTG-1];
    assign mag       = root_reg[NSTG-1];
    assign side_out  = side_reg[NSTG-1];

endmodule

// ===== hw/rtl/v3n_div.sv =====
// three-lane pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module v3n_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  v3n_pkg::root_t                    mag_in,
    input  v3n_pkg::side_t                    side_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output v3n_pkg::root_t                    mag_out,
    output logic [v3n_pkg::LANES-1:0]         neg_out,
    output logic [v3n_pkg::LANES-1:0][v3n_pkg::QUOT_W-1:0] quot_out
);
    import v3n_pkg::*;

    localparam int NSTG = QUOT_W;

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   rdy;

    root_t            mag_reg [NSTG];
    logic [LANES-1:0] neg_reg [NSTG];

    assign rdy[NSTG] = out_ready;

    genvar k, l;
    generate
        for (k = 0; k < NSTG; k++) begin : g_stage
            root_t            mag_prev;
            logic [LANES-1:0] neg_prev;

            assign rdy[k] = !v_reg[k] || rdy[k+1];

            if (k == 0) begin : g_first
                assign mag_prev = mag_in;
                assign neg_prev = side_in.neg;
            end else begin : g_next
                assign mag_prev = mag_reg[k-1];
                assign neg_prev = neg_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k])
                begin
                    mag_reg[k] <= mag_prev;
                    neg_reg[k] <= neg_prev;
                end
            end
        end

        for (l = 0; l < LANES; l++) begin : g_lane
            div_t  rem_reg  [NSTG];
            quot_t quot_reg [NSTG];

            for (k = 0; k < NSTG; k++) begin : g_bit
                localparam int BIT = NSTG - 1 - k;
                div_t  rem_prev;
                quot_t quot_prev;
                div_t  dshift;
                logic  take;

                if (k == 0) begin : g_first
                    assign rem_prev  = div_t'(side_in.abs_val[l]) << UNIT_FRAC;
                    assign quot_prev = '0;
                    assign dshift    = div_t'(mag_in) << BIT;
                end else begin : g_next
                    assign rem_prev  = rem_reg[k-1];
                    assign quot_prev = quot_reg[k-1];
                    assign dshift    = div_t'(mag_reg[k-1]) << BIT;
                end

                assign take = rem_prev >= dshift;

                always_ff @(posedge clk)
                begin
                    if (rdy[k])
                    begin
                        rem_reg[k]  <= take ? (rem_prev - dshift) : rem_prev;
                        quot_reg[k] <= take ? (quot_prev | (quot_t'(1) << BIT)) : quot_prev;
                    end
                end
            end

            assign quot_out[l] = quot_reg[NSTG-1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int s = 1; s < NSTG; s++)
            begin
                if (rdy[s])
                    v_reg[s] <= v_reg[s-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NSTG-1];
    assign mag_out   = mag_reg[NSTG-1];
    assign neg_out   = neg_reg[NSTG-1];

endmodule

// ===== hw/rtl/vector3_normalize.sv =====
// top level of the 3d vector normalizer
`timescale 1ns / 1ps
`include "vector3_normalize_macros.svh"
// Normalizes one signed Q7.8 vector per transaction: magnitude is the truncated
// square root of x*x + y*y + z*z in unsigned Q8.8, and each unit component is
// the component divided by that magnitude, truncated toward zero to signed
// Q1.14 (16384 = 1.0). A zero vector raises zero_length and returns zero
// components. For a 2D vector drive vec_z with zero. The pipeline accepts one
// transaction per clock and keeps doing so while results are stalled until
// all stages fill. From input to output a transaction passes the stages for
// absolute value, squaring and summing, the square root stages (one root bit
// per stage), the three parallel dividers (one quotient bit per stage) and the
// output register that applies sign, zero forcing and the magnitude clamp.
// Each stage holds its own valid bit, so bubbles close up under stall.
module vector3_normalize (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic signed [v3n_pkg::COMPONENT_WIDTH-1:0] vec_x,
    input  logic signed [v3n_pkg::COMPONENT_WIDTH-1:0] vec_y,
    input  logic signed [v3n_pkg::COMPONENT_WIDTH-1:0] vec_z,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic        [v3n_pkg::OUT_W-1:0]           magnitude,
    output logic signed [v3n_pkg::OUT_W-1:0]           unit_x,
    output logic signed [v3n_pkg::OUT_W-1:0]           unit_y,
    output logic signed [v3n_pkg::OUT_W-1:0]           unit_z,
    output logic                                       zero_length
);
    import v3n_pkg::*;

    // square stage to root stage
    logic  sq_valid, sq_ready;
    sum_t  sq_sum;
    side_t sq_side;

    // root stage to divider
    logic  rt_valid, rt_ready;
    root_t rt_mag;
    side_t rt_side;

    // divider to output register
    logic                         dv_valid, dv_ready;
    root_t                        dv_mag;
    logic [LANES-1:0]             dv_neg;
    logic [LANES-1:0][QUOT_W-1:0] dv_quot;

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      mag_reg;
    logic [OUT_W-1:0]      unit_reg [LANES];
    logic                  zero_reg;
    logic [OUT_W-1:0]      unit_next [LANES];
    logic                  zero_next;

    v3n_sqsum u_sqsum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .sum       (sq_sum),
        .side      (sq_side)
    );

    v3n_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .sum       (sq_sum),
        .side_in   (sq_side),
        .out_valid (rt_valid),
        .out_ready (rt_ready),
        .mag       (rt_mag),
        .side_out  (rt_side)
    );

    v3n_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .in_ready  (rt_ready),
        .mag_in    (rt_mag),
        .side_in   (rt_side),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .mag_out   (dv_mag),
        .neg_out   (dv_neg),
        .quot_out  (dv_quot)
    );

    // output register: skid point between pipeline and consumer
    assign dv_ready  = !out_valid_reg || out_ready;
    // zero magnitude only happens for the all-zero vector
    assign zero_next = (dv_mag == '0);

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (zero_next)
                unit_next[l] = '0;
            else if (dv_neg[l])
                unit_next[l] = OUT_W'(0) - OUT_W'(dv_quot[l]);
            else
                unit_next[l] = OUT_W'(dv_quot[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (dv_ready)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready)
        begin
            mag_reg  <= sat_mag(dv_mag);
            zero_reg <= zero_next;
            for (int l = 0; l < LANES; l++)
                unit_reg[l] <= unit_next[l];
        end
    end

    assign out_valid   = out_valid_reg;
    assign magnitude   = mag_reg;
    assign unit_x      = unit_reg[0];
    assign unit_y      = unit_reg[1];
    assign unit_z      = unit_reg[2];
    assign zero_length = zero_reg;

    // zero vector gives zero magnitude and zero components
    `V3N_ASSERT_IMP(a_zero_mag, clk, rst_n, out_valid && zero_length,
        magnitude == '0)
    `V3N_ASSERT_IMP(a_zero_unit, clk, rst_n, out_valid && zero_length,
        unit_x == '0 && unit_y == '0 && unit_z == '0)
    // unit components never exceed one in magnitude
    `V3N_ASSERT_IMP(a_unit_range, clk, rst_n, out_valid && !zero_length,
        unit_x >= -16'sd16384 && unit_x <= 16'sd16384 &&
        unit_y >= -16'sd16384 && unit_y <= 16'sd16384 &&
        unit_z >= -16'sd16384 && unit_z <= 16'sd16384)

endmodule
